FILE: rtl/mtct_pkg.sv
// Package for the markup tag closure tracker.
// Holds the tag pattern tables, request and operation codes, and shared types.
// No dependencies.
package mtct_pkg;

    // Request codes on the input channel.
    localparam logic [1:0] REQ_TEXT  = 2'd0;
    localparam logic [1:0] REQ_LINE  = 2'd1;
    localparam logic [1:0] REQ_FLUSH = 2'd2;

    // Tag pattern table.
    localparam int NUM_PATTERNS    = 11;
    localparam int MAX_PATTERN_LEN = 12;

    localparam logic [7:0] PAT_CHAR [NUM_PATTERNS][MAX_PATTERN_LEN] = '{
        '{"<", "i", ">", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"<", "/", "i", ">", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"<", "b", ">", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"<", "/", "b", ">", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"<", "u", ">", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"<", "/", "u", ">", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"<", "s", ">", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"<", "/", "s", ">", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"<", "f", "o", "n", "t", " ", "c", "o", "l", "o", "r", "="},
        '{"<", "f", "o", "n", "t", " ", "s", "i", "z", "e", "=", 8'h00},
        '{"<", "/", "f", "o", "n", "t", ">", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] PAT_LEN [NUM_PATTERNS] = '{
        4'd3, 4'd4, 4'd3, 4'd4, 4'd3, 4'd4, 4'd3, 4'd4, 4'd12, 4'd11, 4'd7
    };

    localparam logic [2:0] PAT_KIND [NUM_PATTERNS] = '{
        3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4
    };

    localparam logic PAT_OPEN [NUM_PATTERNS] = '{
        1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0
    };

    // Operation queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_FLUSH
    } t_op_code;

    typedef struct packed {
        t_op_code   code;
        logic [2:0] kind;
    } t_op;

    // One result item.
    typedef struct packed {
        logic [2:0] closure_tag;
        logic       none_open;
        logic       overflowed;
        logic       last;
    } t_result;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_SHIFT,
        BK_FLUSH_OUT,
        BK_FLUSH_NONE
    } t_back_state;

endpackage

FILE: rtl/mtct_front.sv
// Front end of the markup tag closure tracker: accepts requests and matches tags.
// Emits push, pop and flush operations. Depends on mtct_pkg.
module mtct_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [1:0]    i_req_type,
    input  logic [7:0]    i_char_byte,
    input  logic          i_queue_full,
    output logic          o_op_valid,
    output mtct_pkg::t_op o_op
);

    logic [3:0]                          r_off;
    logic [3:0]                          n_off;
    logic [mtct_pkg::NUM_PATTERNS-1:0]   r_alive;
    logic [mtct_pkg::NUM_PATTERNS-1:0]   n_alive;
    logic [mtct_pkg::NUM_PATTERNS-1:0]   keep;
    logic [7:0]                          lc;
    logic [3:0]                          off_inc;
    logic                                hit;
    logic [2:0]                          hit_kind;
    logic                                hit_open;
    logic                                accept;

    assign o_stall = i_queue_full;
    assign accept  = i_valid && !i_queue_full;
    assign off_inc = r_off + 4'd1;

    // Fold upper-case letters to lower case.
    always_comb begin
        lc = i_char_byte;
        if (i_char_byte >= "A" && i_char_byte <= "Z") begin
            lc = i_char_byte + 8'd32;
        end
    end

    // Patterns that still match after this byte, and the first one completed.
    always_comb begin
        keep     = '0;
        hit      = 1'b0;
        hit_kind = 3'd0;
        hit_open = 1'b0;
        for (int p = 0; p < mtct_pkg::NUM_PATTERNS; p++) begin
            keep[p] = r_alive[p] && (r_off < mtct_pkg::PAT_LEN[p]) &&
                      (mtct_pkg::PAT_CHAR[p][r_off] == lc);
        end
        for (int p = mtct_pkg::NUM_PATTERNS - 1; p >= 0; p--) begin
            if (keep[p] && (mtct_pkg::PAT_LEN[p] == off_inc)) begin
                hit      = 1'b1;
                hit_kind = mtct_pkg::PAT_KIND[p];
                hit_open = mtct_pkg::PAT_OPEN[p];
            end
        end
    end

    // Matcher update and operation selection.
    always_comb begin
        n_off      = r_off;
        n_alive    = r_alive;
        o_op_valid = 1'b0;
        o_op.code  = mtct_pkg::OP_FLUSH;
        o_op.kind  = 3'd0;
        unique case (i_req_type)
            mtct_pkg::REQ_TEXT: begin
                if (lc == "<") begin
                    n_off   = 4'd1;
                    n_alive = '1;
                end else if (r_off == 4'd0 ||
                             r_off >= 4'(mtct_pkg::MAX_PATTERN_LEN)) begin
                    n_off   = '0;
                    n_alive = '0;
                end else if (keep == '0) begin
                    n_off   = '0;
                    n_alive = '0;
                end else if (hit) begin
                    n_off      = '0;
                    n_alive    = '0;
                    o_op_valid = 1'b1;
                    o_op.code  = hit_open ? mtct_pkg::OP_PUSH : mtct_pkg::OP_POP;
                    o_op.kind  = hit_kind;
                end else begin
                    n_off   = off_inc;
                    n_alive = keep;
                end
            end
            mtct_pkg::REQ_LINE: begin
                n_off   = '0;
                n_alive = '0;
            end
            mtct_pkg::REQ_FLUSH: begin
                n_off      = '0;
                n_alive    = '0;
                o_op_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Matcher registers advance on each accepted transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off   <= '0;
            r_alive <= '0;
        end else if (accept) begin
            r_off   <= n_off;
            r_alive <= n_alive;
        end
    end

endmodule

FILE: rtl/mtct_fifo.sv
// Short operation queue between the front and back of the tag tracker.
// Show-ahead read of the head entry. Depends on mtct_pkg.
module mtct_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  mtct_pkg::t_op i_wr_data,
    input  logic          i_rd_en,
    output mtct_pkg::t_op o_rd_data,
    output logic          o_full,
    output logic          o_empty
);

    localparam int CNTW = mtct_pkg::QUEUE_AW + 1;

    mtct_pkg::t_op                 r_mem [mtct_pkg::QUEUE_DEPTH];
    logic [mtct_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [mtct_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [CNTW-1:0]               r_count;
    logic                          do_wr;
    logic                          do_rd;

    assign o_full    = (r_count == CNTW'(mtct_pkg::QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign do_wr     = i_wr_en && !o_full;
    assign do_rd     = i_rd_en && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

FILE: rtl/mtct_back.sv
// Back end of the tag tracker: open-tag stack memory and flush sequencer.
// Drives the registered result channel. Depends on mtct_pkg.
module mtct_back #(
    parameter int STACK_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    input  mtct_pkg::t_op     i_op,
    input  logic              i_op_empty,
    output logic              o_op_rd,
    output logic              o_valid,
    input  logic              i_stall,
    output mtct_pkg::t_result o_result,
    output logic [$clog2(STACK_DEPTH+1)-1:0] o_count
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [2:0]            r_mem [STACK_DEPTH];
    logic [2:0]            r_rd_data;
    mtct_pkg::t_back_state r_state;
    mtct_pkg::t_back_state n_state;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [CW-1:0]         r_idx;
    logic [CW-1:0]         n_idx;
    logic [2:0]            r_kind;
    logic [2:0]            n_kind;
    logic                  r_ovf;
    logic                  n_ovf;
    logic                  r_enable;
    logic                  r_out_valid;
    mtct_pkg::t_result     r_out;
    logic                  out_free;
    logic                  out_load;
    mtct_pkg::t_result     out_data;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [2:0]            wr_data;
    logic [CW-1:0]         idx_dec;

    assign out_free = !r_out_valid || !i_stall;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;
    assign o_count  = r_count;
    assign idx_dec  = r_idx - 1'b1;

    // Sequencer: stack updates, tag search with shift-down, flush emission.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_kind   = r_kind;
        n_ovf    = r_ovf;
        o_op_rd  = 1'b0;
        out_load = 1'b0;
        out_data = '0;
        wr_en    = 1'b0;
        wr_addr  = r_count[IW-1:0];
        wr_data  = i_op.kind;
        unique case (r_state)
            mtct_pkg::BK_IDLE: begin
                if (!i_op_empty) begin
                    o_op_rd = 1'b1;
                    n_kind  = i_op.kind;
                    unique case (i_op.code)
                        mtct_pkg::OP_PUSH: begin
                            if (r_count >= CW'(STACK_DEPTH)) begin
                                n_ovf = 1'b1;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        mtct_pkg::OP_POP: begin
                            if (r_count != '0) begin
                                n_idx   = r_count - 1'b1;
                                n_state = mtct_pkg::BK_SCAN;
                            end
                        end
                        mtct_pkg::OP_FLUSH: begin
                            if (r_enable && r_count != '0) begin
                                n_idx   = r_count - 1'b1;
                                n_state = mtct_pkg::BK_FLUSH_OUT;
                            end else begin
                                n_state = mtct_pkg::BK_FLUSH_NONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            mtct_pkg::BK_SCAN: begin
                // The read data holds the entry at the scan index.
                if (r_rd_data == r_kind) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = mtct_pkg::BK_SHIFT;
                end else if (r_idx == '0) begin
                    n_state = mtct_pkg::BK_IDLE;
                end else begin
                    n_idx = idx_dec;
                end
            end
            mtct_pkg::BK_SHIFT: begin
                // The index points at the source entry; copy it one place down.
                if (r_idx < r_count) begin
                    wr_en   = 1'b1;
                    wr_addr = idx_dec[IW-1:0];
                    wr_data = r_rd_data;
                    n_idx   = r_idx + 1'b1;
                end else begin
                    n_count = r_count - 1'b1;
                    n_state = mtct_pkg::BK_IDLE;
                end
            end
            mtct_pkg::BK_FLUSH_OUT: begin
                if (out_free) begin
                    out_load             = 1'b1;
                    out_data.closure_tag = r_rd_data;
                    out_data.none_open   = 1'b0;
                    out_data.overflowed  = r_ovf;
                    out_data.last        = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = mtct_pkg::BK_IDLE;
                    end else begin
                        n_idx = idx_dec;
                    end
                end
            end
            mtct_pkg::BK_FLUSH_NONE: begin
                if (out_free) begin
                    out_load             = 1'b1;
                    out_data.closure_tag = 3'd0;
                    out_data.none_open   = 1'b1;
                    out_data.overflowed  = r_ovf;
                    out_data.last        = 1'b1;
                    n_count              = '0;
                    n_ovf                = 1'b0;
                    n_state              = mtct_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = mtct_pkg::BK_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mtct_pkg::BK_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_ovf       <= 1'b0;
            r_enable    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_ovf   <= n_ovf;
            if (i_cfg_wr_en) begin
                r_enable <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        if (out_load) begin
            r_out <= out_data;
        end
    end

    // Stack memory: one write port, one registered read port at the next index.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[n_idx[IW-1:0]];
    end

endmodule

FILE: rtl/markup_tag_closure_tracker.sv
// Top level of the markup tag closure tracker.
// Instantiates mtct_front, mtct_fifo and mtct_back; depends on mtct_pkg.
//
// Usage:
// The input channel (i_valid, o_stall) carries one request per transfer:
// a text byte, an end of line, or an end of subtitle (flush). A byte is
// matched against the tag patterns in the cycle of its transfer, so the
// front takes one request per cycle while the operation queue has room.
// Completed tags and flushes pass through a four-entry queue to the back,
// which keeps the open-tag stack in a memory.
// A closing tag scans the stack from the top, one entry per cycle, then
// copies the newer entries down one per cycle; this scan and copy over
// the stack memory set the worst-case rate.
// A flush gives one result per cycle while the receiver does not stall;
// the last result carries o_last.
// Results leave through an output register (o_valid, i_stall). While the
// receiver stalls, the result holds and the back waits to emit the next one;
// the front keeps accepting until the queue fills. Synchronous reset
// empties the stack and queue, clears the matcher and sets closure enable
// to one.
module markup_tag_closure_tracker #(
    parameter int STACK_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_char_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_closure_tag,
    output logic       o_none_open,
    output logic       o_overflowed,
    output logic       o_last
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic              op_valid;
    mtct_pkg::t_op     op;
    mtct_pkg::t_op     head_op;
    logic              queue_full;
    logic              queue_empty;
    logic              queue_rd;
    mtct_pkg::t_result result;
    logic [CW-1:0]     count;

    // Request acceptance and tag matching.
    mtct_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_char_byte  (i_char_byte),
        .i_queue_full (queue_full),
        .o_op_valid   (op_valid),
        .o_op         (op)
    );

    // Operation queue.
    mtct_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_valid && !queue_full && op_valid),
        .i_wr_data (op),
        .i_rd_en   (queue_rd),
        .o_rd_data (head_op),
        .o_full    (queue_full),
        .o_empty   (queue_empty)
    );

    // Stack and flush sequencer.
    mtct_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_op          (head_op),
        .i_op_empty    (queue_empty),
        .o_op_rd       (queue_rd),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result      (result),
        .o_count       (count)
    );

    assign o_closure_tag = result.closure_tag;
    assign o_none_open   = result.none_open;
    assign o_overflowed  = result.overflowed;
    assign o_last        = result.last;

    // The stack fill never exceeds its depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= CW'(STACK_DEPTH))
        else $error("stack fill count exceeds depth");

    // A nothing-to-close result is always the last of its flush with tag zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_none_open) |-> (o_last && o_closure_tag == 3'd0))
        else $error("none-open result malformed");

    // A reported closure names a real tag type.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_none_open) |-> (o_closure_tag <= 3'd4))
        else $error("closure tag out of range");

    // A stalled result stays valid and unchanged.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(result)))
        else $error("stalled result changed");

endmodule

FILE: bench/closure_checker.sv
`timescale 1ns / 1ps
// Checker for the markup tag closure tracker: watches both channels and the register port.
// Predicts the closure results of every flush and compares each result transfer.
// Depends on mtct_pkg for the request codes and the result type.
module closure_checker #(
    parameter int STACK_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_req_valid,
    input  logic       i_req_stall,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_char_byte,
    input  logic       i_res_valid,
    input  logic       i_res_stall,
    input  logic [2:0] i_closure_tag,
    input  logic       i_none_open,
    input  logic       i_overflowed,
    input  logic       i_last,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int NUM_TAGS     = 11;
    localparam int LONGEST_TAG  = 12;
    localparam int REPORT_LIMIT = 10;

    typedef enum logic [2:0] {
        K_ITALIC,
        K_BOLD,
        K_UNDERLINE,
        K_STRIKE,
        K_FONT
    } t_tag_kind;

    // Predicted state of the tracker.
    logic [2:0]          open_stack [STACK_DEPTH];
    int                  open_depth;
    int                  match_pos;
    logic [NUM_TAGS-1:0] live_tags;
    logic                dropped_open;
    logic                closure_on;
    mtct_pkg::t_result   closures_due [$];
    int                  fails;

    // Recognized tags; even slots below eight open a tag, odd ones close it.
    function automatic string tag_text(int p);
        case (p)
            0: return "<i>";
            1: return "</i>";
            2: return "<b>";
            3: return "</b>";
            4: return "<u>";
            5: return "</u>";
            6: return "<s>";
            7: return "</s>";
            8: return "<font color=";
            9: return "<font size=";
            default: return "</font>";
        endcase
    endfunction

    always @(posedge i_clk) begin : monitor
        mtct_pkg::t_result   want;
        mtct_pkg::t_result   got;
        logic [7:0]          c;
        logic [NUM_TAGS-1:0] keep;
        t_tag_kind           kind;
        string               t;
        int                  hit;
        int                  n;
        int                  m;
        bit                  found;

        if (!i_rst_n) begin
            open_depth   = 0;
            match_pos    = 0;
            live_tags    = '0;
            dropped_open = 1'b0;
            closure_on   = 1'b1;
            fails        = 0;
            closures_due.delete();
        end else begin
            // Compare a result transfer with the oldest outstanding closure.
            if (i_res_valid && !i_res_stall) begin
                got.closure_tag = i_closure_tag;
                got.none_open   = i_none_open;
                got.overflowed  = i_overflowed;
                got.last        = i_last;
                if (closures_due.size() == 0) begin
                    if (fails < REPORT_LIMIT)
                        $display({"%0t: unexpected result: tag %0d none_open %0b ",
                                  "overflowed %0b last %0b"},
                                 $time, got.closure_tag, got.none_open, got.overflowed,
                                 got.last);
                    fails++;
                end else begin
                    want = closures_due.pop_front();
                    if (got !== want) begin
                        if (fails < REPORT_LIMIT)
                            $display({"%0t: result mismatch: expected tag %0d none_open %0b ",
                                      "overflowed %0b last %0b, got tag %0d none_open %0b ",
                                      "overflowed %0b last %0b"},
                                     $time, want.closure_tag, want.none_open, want.overflowed,
                                     want.last, got.closure_tag, got.none_open, got.overflowed,
                                     got.last);
                        fails++;
                    end
                end
            end

            if (i_cfg_wr_en)
                closure_on = i_cfg_wr_data;

            // Advance the prediction on every request transfer.
            if (i_req_valid && !i_req_stall) begin
                case (i_req_type)
                    mtct_pkg::REQ_TEXT: begin
                        c = (i_char_byte >= "A" && i_char_byte <= "Z") ?
                            i_char_byte + 8'd32 : i_char_byte;
                        if (c == "<") begin
                            // An angle bracket always starts a fresh candidate.
                            match_pos = 1;
                            live_tags = '1;
                        end else if (match_pos == 0 || match_pos >= LONGEST_TAG) begin
                            match_pos = 0;
                            live_tags = '0;
                        end else begin
                            keep = '0;
                            for (int p = 0; p < NUM_TAGS; p++) begin
                                t = tag_text(p);
                                if (live_tags[p] && match_pos < t.len() && t[match_pos] == c)
                                    keep[p] = 1'b1;
                            end
                            match_pos++;
                            live_tags = keep;
                            hit = -1;
                            for (int p = 0; p < NUM_TAGS; p++) begin
                                t = tag_text(p);
                                if (hit < 0 && keep[p] && t.len() == match_pos)
                                    hit = p;
                            end
                            if (keep == '0 || hit >= 0) begin
                                match_pos = 0;
                                live_tags = '0;
                            end
                            if (hit >= 0) begin
                                kind = (hit < 8) ? t_tag_kind'(hit / 2) : K_FONT;
                                if ((hit < 8) ? (hit % 2 == 0) : (hit != 10)) begin
                                    // Opening tag: a full stack drops it and flags it.
                                    if (open_depth >= STACK_DEPTH) begin
                                        dropped_open = 1'b1;
                                    end else begin
                                        open_stack[open_depth] = kind;
                                        open_depth++;
                                    end
                                end else begin
                                    // Closing tag: remove the newest match, shift newer down.
                                    found = 1'b0;
                                    for (n = open_depth - 1; n >= 0; n--) begin
                                        if (!found && open_stack[n] == kind) begin
                                            found = 1'b1;
                                            for (m = n; m + 1 < open_depth; m++)
                                                open_stack[m] = open_stack[m + 1];
                                            open_depth--;
                                        end
                                    end
                                end
                            end
                        end
                    end
                    mtct_pkg::REQ_LINE: begin
                        match_pos = 0;
                        live_tags = '0;
                    end
                    mtct_pkg::REQ_FLUSH: begin
                        // Report missing closures newest first, or else one none-open result, then clear.
                        if (closure_on && open_depth > 0) begin
                            for (n = open_depth - 1; n >= 0; n--) begin
                                want.closure_tag = open_stack[n];
                                want.none_open   = 1'b0;
                                want.overflowed  = dropped_open;
                                want.last        = (n == 0);
                                closures_due.push_back(want);
                            end
                        end else begin
                            want.closure_tag = K_ITALIC;
                            want.none_open   = 1'b1;
                            want.overflowed  = dropped_open;
                            want.last        = 1'b1;
                            closures_due.push_back(want);
                        end
                        open_depth   = 0;
                        dropped_open = 1'b0;
                        match_pos    = 0;
                        live_tags    = '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= closures_due.size();
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Top of the bench for the markup tag closure tracker: clock, reset, stimulus and verdict.
// Instantiates markup_tag_closure_tracker and closure_checker; depends on mtct_pkg.
module testbench;

    localparam int         STACK_DEPTH   = 16;
    localparam logic [1:0] REQ_UNUSED    = 2'd3;
    localparam int         SETTLE_CYCLES = 2 * STACK_DEPTH + 8;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         IDLE_LIMIT    = 3000;
    localparam int         PHASE_ITEMS   = 90;
    localparam int         NUM_PHASES    = 5;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic       i_cfg_wr_data;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_req_type;
    logic [7:0] i_char_byte;
    logic       o_valid;
    logic       i_stall;
    logic [2:0] o_closure_tag;
    logic       o_none_open;
    logic       o_overflowed;
    logic       o_last;

    int fail_count;
    int pending;
    int items_sent    = 0;
    int hold_requests = 0;
    int idle_cycles   = 0;
    bit tx_burst      = 1'b0;
    bit rx_quiet      = 1'b0;

    markup_tag_closure_tracker #(
        .STACK_DEPTH(STACK_DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_char_byte   (i_char_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_closure_tag (o_closure_tag),
        .o_none_open   (o_none_open),
        .o_overflowed  (o_overflowed),
        .o_last        (o_last)
    );

    closure_checker #(
        .STACK_DEPTH(STACK_DEPTH)
    ) i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req_valid   (i_valid),
        .i_req_stall   (o_stall),
        .i_req_type    (i_req_type),
        .i_char_byte   (i_char_byte),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_closure_tag (o_closure_tag),
        .i_none_open   (o_none_open),
        .i_overflowed  (o_overflowed),
        .i_last        (o_last),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #5 i_clk = ~i_clk;

    // Mostly no gap, sometimes a few cycles, rarely a long pause.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic string opening_tag(int unsigned n);
        case (n)
            0: return "<i>";
            1: return "<b>";
            2: return "<u>";
            3: return "<s>";
            4: return "<font color=";
            default: return "<font size=";
        endcase
    endfunction

    function automatic string closing_tag(int unsigned n);
        case (n)
            0: return "</i>";
            1: return "</b>";
            2: return "</u>";
            3: return "</s>";
            default: return "</font>";
        endcase
    endfunction

    // Offer one request and hold it until the transfer happens.
    task automatic send(input logic [1:0] req, input logic [7:0] b);
        int gap;
        i_valid     <= 1'b1;
        i_req_type  <= req;
        i_char_byte <= b;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        if (req != REQ_UNUSED)
            items_sent++;
        gap = tx_burst ? 0 : gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Send a string byte by byte, optionally with random letter case.
    task automatic send_text(input string s, input bit mix_case);
        logic [7:0] c;
        for (int n = 0; n < s.len(); n++) begin
            c = s[n];
            if (mix_case && c >= "a" && c <= "z" && $urandom_range(0, 1))
                c = c - 8'd32;
            send(mtct_pkg::REQ_TEXT, c);
        end
    endtask

    // Stop offering and wait until every closure has come back and the back end is quiet.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_closure(input logic on);
        settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= on;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // One subtitle of mostly well-formed tags with some noise, ended by a flush.
    task automatic random_subtitle();
        int    tokens;
        int    r;
        bit    crowded;
        string t;
        crowded = ($urandom_range(0, 7) == 0);
        tokens  = crowded ? $urandom_range(17, 22) : $urandom_range(1, 10);
        for (int n = 0; n < tokens; n++) begin
            // A crowded subtitle opens more tags than the stack holds.
            r = (crowded && n < 17) ? 0 : $urandom_range(0, 99);
            if (r < 45) begin
                send_text(opening_tag($urandom_range(0, 5)), 1'b1);
            end else if (r < 70) begin
                send_text(closing_tag($urandom_range(0, 4)), 1'b1);
            end else if (r < 84) begin
                repeat ($urandom_range(1, 4))
                    send(mtct_pkg::REQ_TEXT, 8'($urandom_range(0, 255)));
            end else if (r < 91) begin
                send(mtct_pkg::REQ_LINE, 8'($urandom_range(0, 255)));
            end else if (r < 97) begin
                // Broken tag: a prefix cut by a line end, a random byte or a new bracket.
                t = $urandom_range(0, 1) ? opening_tag($urandom_range(0, 5))
                                         : closing_tag($urandom_range(0, 4));
                send_text(t.substr(0, $urandom_range(0, t.len() - 2)), 1'b1);
                case ($urandom_range(0, 2))
                    0: send(mtct_pkg::REQ_LINE, 8'($urandom_range(0, 255)));
                    1: send(mtct_pkg::REQ_TEXT, 8'($urandom_range(0, 255)));
                    default: send(mtct_pkg::REQ_TEXT, "<");
                endcase
            end else begin
                send(REQ_UNUSED, 8'($urandom_range(0, 255)));
            end
        end
        send(mtct_pkg::REQ_FLUSH, 8'($urandom_range(0, 255)));
    endtask

    // Receiver: random stalls, quiet stretches, and long hold-offs on request.
    initial begin : receiver
        int holds_done;
        int n;
        holds_done = 0;
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (holds_done != hold_requests) begin
                holds_done++;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_quiet) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                n = gap_len();
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
                i_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    // Watchdog: too long without any transfer on either channel ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("markup_tag_closure_tracker test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int target;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 1'b0;
        i_valid       <= 1'b0;
        i_req_type    <= mtct_pkg::REQ_TEXT;
        i_char_byte   <= 8'h00;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty flush, case folding, line end inside a tag, byte extremes,
        // bracket inside a candidate, unused request, closing an older entry.
        send(mtct_pkg::REQ_FLUSH, 8'h00);
        send_text("<I><b", 1'b0);
        send(mtct_pkg::REQ_LINE, 8'hFF);
        send(mtct_pkg::REQ_TEXT, ">");
        send(mtct_pkg::REQ_TEXT, 8'h00);
        send(mtct_pkg::REQ_TEXT, 8'hFF);
        send_text("<<U>", 1'b0);
        send(REQ_UNUSED, 8'hA5);
        send_text("</I>", 1'b0);
        send(mtct_pkg::REQ_FLUSH, 8'h55);
        // With closing disabled an open tag still gives a single empty result.
        write_closure(1'b0);
        send_text("<s>", 1'b0);
        send(mtct_pkg::REQ_FLUSH, 8'hAA);
        write_closure(1'b1);

        // Random phases: normal traffic, closing off, back to back, held receiver.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            write_closure((phase == 1 || phase == NUM_PHASES - 1) ? 1'b0 : 1'b1);
            tx_burst = (phase == 2 || phase == 3);
            rx_quiet = (phase == 2);
            if (phase == 3)
                hold_requests++;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                random_subtitle();
        end

        settle();
        if (fail_count == 0)
            $display("markup_tag_closure_tracker test passed");
        else
            $display("markup_tag_closure_tracker test failed");
        $finish;
    end

endmodule
